FILE: rtl/ortf_pkg.sv
`timescale 1ns / 1ps

package ortf_pkg;

  localparam int unsigned DEPTH    = 4096;
  localparam int unsigned MAX_READ = 64;

  localparam int unsigned AW  = $clog2(DEPTH);
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned RCW = 7;
  localparam int unsigned BW  = 8;
  localparam int unsigned KW  = 2;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef enum logic [KW-1:0] {
    KIND_STATUS = 2'd0,
    KIND_BUF    = 2'd1,
    KIND_PAD    = 2'd2
  } byte_kind_e;

  typedef struct packed {
    logic wr_en;
    logic start_rd;
    logic step_rd;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

FILE: rtl/ortf_ctrl.sv
`timescale 1ns / 1ps

module ortf_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   req_type_i,
  input  logic                   out_stall_i,
  input  ortf_pkg::dp_status_t   status_i,
  output ortf_pkg::dp_cmd_t      cmd_o,
  output logic                   in_stall_o,
  output logic                   out_valid_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == ortf_pkg::REQ_WRITE) begin
            cmd_o.wr_en = 1'b1;
          end else begin
            cmd_o.start_rd = 1'b1;
            state_d        = ST_BUSY;
          end
        end
      end
      ST_BUSY: begin
        if (!out_stall_i) begin
          if (status_i.last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.step_rd = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_BUSY);

  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.wr_en, cmd_o.start_rd, cmd_o.step_rd}) <= 1)
    else $error("more than one datapath command");

  a_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step_rd |-> (out_valid_o && !out_stall_i && !status_i.last))
    else $error("step issued outside an accepted non-final result");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start_rd |=> out_valid_o)
    else $error("read start did not raise a result");

endmodule

FILE: rtl/ortf_dpath.sv
`timescale 1ns / 1ps

module ortf_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ortf_pkg::dp_cmd_t                 cmd_i,
  input  logic [ortf_pkg::BW-1:0]           data_byte_i,
  input  logic [ortf_pkg::RCW-1:0]          read_count_i,
  output ortf_pkg::dp_status_t              status_o,
  output logic [ortf_pkg::BW-1:0]           out_byte_o,
  output logic [ortf_pkg::KW-1:0]           byte_kind_o,
  output logic                              last_o,
  output logic [ortf_pkg::RCW-1:0]          valid_sent_o,
  output logic [ortf_pkg::CW-1:0]           fill_count_o,
  output logic [ortf_pkg::CW-1:0]           free_count_o
);

  logic [ortf_pkg::BW-1:0]  mem [ortf_pkg::DEPTH];
  logic [ortf_pkg::BW-1:0]  mem_q;

  logic [ortf_pkg::AW-1:0]  wptr_q, wptr_d;
  logic [ortf_pkg::AW-1:0]  rptr_q, rptr_d;
  logic [ortf_pkg::CW-1:0]  held_q, held_d;
  logic [ortf_pkg::RCW-1:0] rem_q, rem_d;
  logic [ortf_pkg::RCW-1:0] sent_q, sent_d;
  ortf_pkg::byte_kind_e     kind_q, kind_d;
  logic                     last_q, last_d;

  logic [ortf_pkg::RCW-1:0] rem_sat, rem_cur, sent_cur;
  logic                     do_step, rd_en, full;

  assign full    = (held_q == ortf_pkg::CW'(ortf_pkg::DEPTH));
  assign do_step = cmd_i.start_rd | cmd_i.step_rd;
  assign rem_sat = (read_count_i > ortf_pkg::RCW'(ortf_pkg::MAX_READ))
                   ? ortf_pkg::RCW'(ortf_pkg::MAX_READ) : read_count_i;
  assign rem_cur  = cmd_i.start_rd ? rem_sat : rem_q;
  assign sent_cur = cmd_i.start_rd ? '0 : sent_q;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    held_d = held_q;
    rem_d  = rem_q;
    sent_d = sent_q;
    kind_d = kind_q;
    last_d = last_q;
    rd_en  = 1'b0;
    if (cmd_i.wr_en) begin
      wptr_d = ortf_pkg::ptr_inc(wptr_q);
      if (full) begin
        rptr_d = ortf_pkg::ptr_inc(rptr_q);
      end else begin
        held_d = held_q + 1'b1;
      end
    end else if (do_step) begin
      if (rem_cur == '0) begin
        kind_d = ortf_pkg::KIND_STATUS;
        last_d = 1'b1;
        sent_d = '0;
        rem_d  = '0;
      end else begin
        last_d = (rem_cur == ortf_pkg::RCW'(1));
        rem_d  = rem_cur - 1'b1;
        if (held_q != '0) begin
          kind_d = ortf_pkg::KIND_BUF;
          rd_en  = 1'b1;
          rptr_d = ortf_pkg::ptr_inc(rptr_q);
          held_d = held_q - 1'b1;
          sent_d = sent_cur + 1'b1;
        end else begin
          kind_d = ortf_pkg::KIND_PAD;
          sent_d = sent_cur;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      held_q <= '0;
      rem_q  <= '0;
      sent_q <= '0;
      kind_q <= ortf_pkg::KIND_STATUS;
      last_q <= 1'b0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      held_q <= held_d;
      rem_q  <= rem_d;
      sent_q <= sent_d;
      kind_q <= kind_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wptr_q] <= data_byte_i;
    end
    if (rd_en) begin
      mem_q <= mem[rptr_q];
    end
  end

  assign status_o.last = last_q;
  assign out_byte_o    = (kind_q == ortf_pkg::KIND_BUF) ? mem_q : '0;
  assign byte_kind_o   = kind_q;
  assign last_o        = last_q;
  assign valid_sent_o  = last_q ? sent_q : '0;
  assign fill_count_o  = held_q;
  assign free_count_o  = ortf_pkg::CW'(ortf_pkg::DEPTH) - held_q;

  a_held_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= ortf_pkg::CW'(ortf_pkg::DEPTH))
    else $error("fill count above depth");

  a_ptr_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q == '0 || full) |-> (rptr_q == wptr_q))
    else $error("pointers disagree with fill count");

  a_buf_sent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kind_q == ortf_pkg::KIND_BUF) |-> (sent_q != '0))
    else $error("buffered byte without sent count");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kind_q == ortf_pkg::KIND_STATUS && last_q) |-> (sent_q == '0))
    else $error("status result with nonzero sent count");

endmodule

FILE: rtl/overwrite_ring_trace_fifo_unit.sv
`timescale 1ns / 1ps
// Write request: no result; writes go one per cycle back to back while no read is in progress.
// Read request of N bytes: first result in the cycle after acceptance, then one result per
// cycle while unstalled (single-port store read, registered); next request taken the
// cycle after the final result leaves.
// Reset (async, active low) empties the ring: pointers and fill count clear, store unset.

module overwrite_ring_trace_fifo_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        req_type_i,
  input  logic [ortf_pkg::BW-1:0]     data_byte_i,
  input  logic [ortf_pkg::RCW-1:0]    read_count_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ortf_pkg::BW-1:0]     out_byte_o,
  output logic [ortf_pkg::KW-1:0]     byte_kind_o,
  output logic                        last_o,
  output logic [ortf_pkg::RCW-1:0]    valid_sent_o,
  output logic [ortf_pkg::CW-1:0]     fill_count_o,
  output logic [ortf_pkg::CW-1:0]     free_count_o
);

  ortf_pkg::dp_cmd_t    cmd;
  ortf_pkg::dp_status_t status;

  ortf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (req_type_i),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  ortf_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .data_byte_i  (data_byte_i),
    .read_count_i (read_count_i),
    .status_o     (status),
    .out_byte_o   (out_byte_o),
    .byte_kind_o  (byte_kind_o),
    .last_o       (last_o),
    .valid_sent_o (valid_sent_o),
    .fill_count_o (fill_count_o),
    .free_count_o (free_count_o)
  );

endmodule

FILE: tb/overwrite_ring_trace_fifo_checker.sv
`timescale 1ns / 1ps

module overwrite_ring_trace_fifo_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic                     req_type_i,
  input  logic [ortf_pkg::BW-1:0]  data_byte_i,
  input  logic [ortf_pkg::RCW-1:0] read_count_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic [ortf_pkg::BW-1:0]  out_byte_i,
  input  logic [ortf_pkg::KW-1:0]  byte_kind_i,
  input  logic                     last_i,
  input  logic [ortf_pkg::RCW-1:0] valid_sent_i,
  input  logic [ortf_pkg::CW-1:0]  fill_count_i,
  input  logic [ortf_pkg::CW-1:0]  free_count_i,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o
);

  import ortf_pkg::*;

  typedef struct packed {
    logic [BW-1:0]  data;
    byte_kind_e     kind;
    logic           last;
    logic [RCW-1:0] sent;
    logic [CW-1:0]  fill;
    logic [CW-1:0]  free;
  } trace_beat_t;

  logic [BW-1:0] ring_mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] held;
  trace_beat_t   beat_q [$];

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, seen);
      fail_count_o++;
    end
  endtask

  task automatic queue_beat(input logic [BW-1:0] data, input byte_kind_e kind,
                            input logic last, input logic [RCW-1:0] sent);
    trace_beat_t beat;
    beat.data = data;
    beat.kind = kind;
    beat.last = last;
    beat.sent = sent;
    beat.fill = held;
    beat.free = CW'(DEPTH) - held;
    beat_q.push_back(beat);
  endtask

  task automatic apply_request(input logic kind, input logic [BW-1:0] data,
                               input logic [RCW-1:0] count);
    logic [RCW-1:0] n;
    logic [RCW-1:0] sent;
    logic           fin;
    if (kind == REQ_WRITE) begin
      ring_mem[wr_ptr] = data;
      wr_ptr = wr_ptr + 1'b1;
      // drop the oldest byte once full
      if (held < CW'(DEPTH)) held = held + 1'b1;
      else rd_ptr = rd_ptr + 1'b1;
    end else begin
      n = (count > RCW'(MAX_READ)) ? RCW'(MAX_READ) : count;
      sent = '0;
      if (n == '0) queue_beat('0, KIND_STATUS, 1'b1, '0);
      for (int unsigned i = 0; i < n; i++) begin
        fin = (i + 1 == n);
        if (held != '0) begin
          data = ring_mem[rd_ptr];
          rd_ptr = rd_ptr + 1'b1;
          held = held - 1'b1;
          sent = sent + 1'b1;
          queue_beat(data, KIND_BUF, fin, fin ? sent : '0);
        end else begin
          queue_beat('0, KIND_PAD, fin, fin ? sent : '0);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    trace_beat_t head;
    if (!rst_ni) begin
      wr_ptr = '0;
      rd_ptr = '0;
      held   = '0;
      beat_q.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (beat_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual byte %0h kind %0d last %0b",
                   $time, out_byte_i, byte_kind_i, last_i);
          fail_count_o++;
        end else begin
          head = beat_q.pop_front();
          check_field("out_byte", 16'(head.data), 16'(out_byte_i));
          check_field("byte_kind", 16'(head.kind), 16'(byte_kind_i));
          check_field("last", 16'(head.last), 16'(last_i));
          check_field("valid_sent", 16'(head.sent), 16'(valid_sent_i));
          check_field("fill_count", 16'(head.fill), 16'(fill_count_i));
          check_field("free_count", 16'(head.free), 16'(free_count_i));
        end
      end
      if (in_valid_i && !in_stall_i) apply_request(req_type_i, data_byte_i, read_count_i);
      pending_o = beat_q.size();
    end
  end

endmodule

FILE: tb/tb_overwrite_ring_trace_fifo_unit.sv
`timescale 1ns / 1ps

module tb_overwrite_ring_trace_fifo_unit;

  import ortf_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 380;
  localparam int unsigned DRAIN_ITEMS = 8;
  localparam int unsigned SETTLE_CYCLES = 8;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           steady = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  logic           req_type = REQ_WRITE;
  logic [BW-1:0]  data_byte = '0;
  logic [RCW-1:0] read_count = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  logic [BW-1:0]  out_byte;
  logic [KW-1:0]  byte_kind;
  logic           last;
  logic [RCW-1:0] valid_sent;
  logic [CW-1:0]  fill_count;
  logic [CW-1:0]  free_count;
  int unsigned    fail_count;
  int unsigned    pending;

  overwrite_ring_trace_fifo_unit dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .req_type_i   (req_type),
    .data_byte_i  (data_byte),
    .read_count_i (read_count),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_byte_o   (out_byte),
    .byte_kind_o  (byte_kind),
    .last_o       (last),
    .valid_sent_o (valid_sent),
    .fill_count_o (fill_count),
    .free_count_o (free_count)
  );

  overwrite_ring_trace_fifo_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .req_type_i   (req_type),
    .data_byte_i  (data_byte),
    .read_count_i (read_count),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_byte_i   (out_byte),
    .byte_kind_i  (byte_kind),
    .last_i       (last),
    .valid_sent_i (valid_sent),
    .fill_count_i (fill_count),
    .free_count_i (free_count),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= !steady && ($urandom_range(99) < 6);
  end

  task automatic send_request(input logic kind, input logic [BW-1:0] data,
                              input logic [RCW-1:0] count);
    if (!steady) begin
      while ($urandom_range(99) < 6) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    data_byte  <= data;
    read_count <= count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    int unsigned    pick;
    logic [RCW-1:0] n_req;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty ring: status, padding, saturated count
    send_request(REQ_READ, 8'h00, 7'd0);
    send_request(REQ_READ, 8'h00, 7'd1);
    send_request(REQ_READ, 8'hFF, 7'd64);
    send_request(REQ_READ, 8'h5A, 7'd127);
    send_request(REQ_WRITE, 8'h00, 7'd127);
    send_request(REQ_WRITE, 8'hFF, 7'd0);
    send_request(REQ_WRITE, 8'hA5, 7'd64);
    send_request(REQ_READ, 8'hFF, 7'd0);
    send_request(REQ_READ, 8'h00, 7'd2);
    send_request(REQ_READ, 8'h00, 7'd3);
    send_request(REQ_WRITE, 8'h5A, 7'd1);
    send_request(REQ_WRITE, 8'h01, 7'd65);
    send_request(REQ_WRITE, 8'h80, 7'd3);
    send_request(REQ_READ, 8'h00, 7'd65);
    send_request(REQ_WRITE, 8'h7F, 7'd0);
    send_request(REQ_READ, 8'h00, 7'd1);
    send_request(REQ_READ, 8'h00, 7'd0);

    for (int unsigned k = 0; k < RANDOM_ITEMS; k++) begin
      if ($urandom_range(99) < 68) begin
        send_request(REQ_WRITE, BW'($urandom_range(255)), RCW'($urandom_range(127)));
      end else begin
        pick = $urandom_range(99);
        if (pick < 8) n_req = '0;
        else if (pick < 14) n_req = RCW'(MAX_READ);
        else if (pick < 20) n_req = RCW'($urandom_range(127, 65));
        else if (pick < 32) n_req = RCW'($urandom_range(63, 9));
        else n_req = RCW'($urandom_range(8, 1));
        send_request(REQ_READ, BW'($urandom_range(255)), n_req);
      end
    end

    for (int unsigned k = 0; k < 24; k++) begin
      if ($urandom_range(1) == 0)
        send_request(REQ_WRITE, BW'($urandom_range(255)), RCW'($urandom_range(127)));
      else
        send_request(REQ_READ, BW'($urandom_range(255)), RCW'($urandom_range(4)));
    end

    // drain back-to-back into padding
    steady <= 1'b1;
    for (int unsigned k = 0; k < DRAIN_ITEMS; k++)
      send_request(REQ_READ, BW'($urandom_range(255)), RCW'(MAX_READ));
    steady <= 1'b0;
    send_request(REQ_READ, 8'h00, 7'd0);

    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ortf_pkg.sv
rtl/ortf_ctrl.sv
rtl/ortf_dpath.sv
rtl/overwrite_ring_trace_fifo_unit.sv
tb/overwrite_ring_trace_fifo_checker.sv
tb/tb_overwrite_ring_trace_fifo_unit.sv
